[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module.
// Both macros expect clk_i in the scope where they are used; CWK_ASSERT also rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset
`define CWK_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cwk checker: property failed");

// Check on every rising edge, reset included
`define CWK_ASSERT_RESET(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("cwk checker: reset property failed");

`endif

[rtl/cwk_pkg.sv]
// ----------------------------------------------------------------------------
// cwk_pkg
// Types, widths and constants of the chroma wedge keyer and hue rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwk_pkg;

  // Pipeline split: key alpha stages, then blend stages
  localparam int AlphaStages = 3;
  localparam int BlendStages = 2;
  localparam int NumStages   = AlphaStages + BlendStages;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 27;

  // Rounding term of the Q16 rotation
  localparam int RotRound = 32768;

  // ceil(2^29 / 255): exact truncating divide by 255 for dividends below 2^21
  localparam int          RecipShift = 29;
  localparam logic [21:0] Recip255   = 22'd2105377;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyCos       = 3'd0,
    RegKeySin       = 3'd1,
    RegKeyOffset    = 3'd2,
    RegWedgeInvSlope = 3'd3,
    RegRangeGain    = 3'd4,
    RegRotateCos    = 3'd5,
    RegRotateSin    = 3'd6,
    RegInvertKey    = 3'd7
  } cwk_reg_e;

  typedef struct packed {
    logic signed [13:0] key_cos;
    logic signed [13:0] key_sin;
    logic signed [21:0] key_offset;
    logic signed [26:0] wedge_inverse_slope;
    logic        [15:0] range_gain;
    logic signed [18:0] rotate_cos;
    logic signed [18:0] rotate_sin;
    logic               invert_key;
  } cwk_cfg_t;

  localparam cwk_cfg_t CfgRst = '{
    key_cos:             14'sd4096,
    key_sin:             14'sd0,
    key_offset:          22'sd0,
    wedge_inverse_slope: 27'sd4096,
    range_gain:          16'd256,
    rotate_cos:          19'sd65536,
    rotate_sin:          19'sd0,
    invert_key:          1'b0
  };

  typedef struct packed {
    logic [7:0] cb_in;
    logic [7:0] cr_in;
  } cwk_in_t;

  typedef struct packed {
    logic [7:0] cb_out;
    logic [7:0] cr_out;
  } cwk_out_t;

  // Hand-off from the key alpha stages to the blend stages
  typedef struct packed {
    logic signed [7:0]  u;
    logic signed [7:0]  v;
    logic signed [11:0] nu;
    logic signed [11:0] nv;
    logic        [7:0]  alpha;
  } cwk_alpha_t;

endpackage

`default_nettype wire

[rtl/cwk_stream_if.sv]
// ----------------------------------------------------------------------------
// cwk_stream_if
// Valid/ready stream channel; one transfer when valid and ready are high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cwk_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[rtl/cwk_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// cwk_pipe_ctrl
// Valid bits and per-stage load enables of the datapath pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwk_pipe_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cwk_pkg::NumStages-1:0]  load_o
);
  import cwk_pkg::*;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] free_c;

  // A stage may load when it is empty or its item moves on this cycle
  always_comb begin
    free_c[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      free_c[k] = !valid_q[k] || free_c[k+1];
    end
  end

  // Advance valid bits with the data; bubbles fill in behind a stall
  always_comb begin
    valid_d = valid_q;
    if (free_c[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (free_c[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign load_o      = free_c;
  assign in_ready_o  = free_c[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

`default_nettype wire

[rtl/cwk_alpha.sv]
// ----------------------------------------------------------------------------
// cwk_alpha
// Key frame rotation, wedge distance, key alpha and the Q16 chroma rotation.
// Three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwk_alpha (
  input  logic                             clk_i,
  input  logic [cwk_pkg::AlphaStages-1:0]  load_i,
  input  cwk_pkg::cwk_in_t                 pix_i,
  input  cwk_pkg::cwk_cfg_t                cfg_i,
  output cwk_pkg::cwk_alpha_t              alpha_o
);
  import cwk_pkg::*;

  // ---------------- stage 1: center and rotate into key frame ----------------
  logic signed [7:0]  u_d, v_d;
  logic signed [21:0] ucos_c, vsin_c, vcos_c, usin_c;
  logic signed [22:0] xs_d, ys_d;

  logic signed [7:0]  u1_q, v1_q;
  logic signed [22:0] xs1_q, ys1_q;

  // Subtracting 128 from an 8-bit sample flips its top bit
  assign u_d = {~pix_i.cb_in[7], pix_i.cb_in[6:0]};
  assign v_d = {~pix_i.cr_in[7], pix_i.cr_in[6:0]};

  assign ucos_c = 22'(u_d) * 22'($signed(cfg_i.key_cos));
  assign vsin_c = 22'(v_d) * 22'($signed(cfg_i.key_sin));
  assign vcos_c = 22'(v_d) * 22'($signed(cfg_i.key_cos));
  assign usin_c = 22'(u_d) * 22'($signed(cfg_i.key_sin));

  assign xs_d = 23'(ucos_c) + 23'(vsin_c);
  assign ys_d = 23'(vcos_c) - 23'(usin_c);

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      u1_q  <= u_d;
      v1_q  <= v_d;
      xs1_q <= xs_d;
      ys1_q <= ys_d;
    end
  end

  // ---------------- stage 2: wedge distance and chroma rotation ----------------
  logic        [10:0] y_c, ay_c;
  logic signed [11:0] ay_s_c;
  logic signed [38:0] slope_c;
  logic signed [22:0] xk_c;
  logic signed [39:0] d_c;
  logic        [28:0] dsat_d;
  logic signed [26:0] rcu_c, rsv_c, rsu_c, rcv_c;
  logic signed [28:0] nus_c, nvs_c;
  logic signed [11:0] nu_d, nv_d;

  logic signed [7:0]  u2_q, v2_q;
  logic        [28:0] dsat2_q;
  logic signed [11:0] nu2_q, nv2_q;

  // Floor shift by 12 is a plain part-select of the two's complement sum
  assign y_c    = ys1_q[22:12];
  assign ay_c   = y_c[10] ? (~y_c + 11'd1) : y_c;
  assign ay_s_c = signed'({1'b0, ay_c});
  assign slope_c = 39'(ay_s_c) * 39'($signed(cfg_i.wedge_inverse_slope));
  assign xk_c   = {xs1_q[22:12], 12'd0};
  assign d_c    = 40'($signed(cfg_i.key_offset)) - 40'(xk_c) + 40'(slope_c);

  // Saturate the distance: negative gives alpha 0, 2^28 and up gives 255
  // for any nonzero gain, so 2^28 stands in for every larger value
  always_comb begin
    if (d_c[39]) begin
      dsat_d = '0;
    end else if (|d_c[38:28]) begin
      dsat_d = {1'b1, 28'd0};
    end else begin
      dsat_d = d_c[28:0];
    end
  end

  assign rcu_c = 27'($signed(cfg_i.rotate_cos)) * 27'(u1_q);
  assign rsv_c = 27'($signed(cfg_i.rotate_sin)) * 27'(v1_q);
  assign rsu_c = 27'($signed(cfg_i.rotate_sin)) * 27'(u1_q);
  assign rcv_c = 27'($signed(cfg_i.rotate_cos)) * 27'(v1_q);

  assign nus_c = 29'(rcu_c) - 29'(rsv_c) + 29'(RotRound);
  assign nvs_c = 29'(rsu_c) + 29'(rcv_c) + 29'(RotRound);

  // Rounded results stay within -1024..1024
  assign nu_d = nus_c[27:16];
  assign nv_d = nvs_c[27:16];

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      u2_q    <= u1_q;
      v2_q    <= v1_q;
      dsat2_q <= dsat_d;
      nu2_q   <= nu_d;
      nv2_q   <= nv_d;
    end
  end

  // ---------------- stage 3: range gain, clamp and invert ----------------
  logic [44:0] prod_c;
  logic [7:0]  alpha_c, alpha_d;

  cwk_alpha_t alpha3_q;

  assign prod_c  = 45'(dsat2_q) * 45'(cfg_i.range_gain);
  assign alpha_c = (|prod_c[44:28]) ? 8'hFF : prod_c[27:20];
  // 255 - alpha is the bitwise complement for 8 bits
  assign alpha_d = cfg_i.invert_key ? ~alpha_c : alpha_c;

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      alpha3_q.u     <= u2_q;
      alpha3_q.v     <= v2_q;
      alpha3_q.nu    <= nu2_q;
      alpha3_q.nv    <= nv2_q;
      alpha3_q.alpha <= alpha_d;
    end
  end

  assign alpha_o = alpha3_q;

endmodule

`default_nettype wire

[rtl/cwk_blend.sv]
// ----------------------------------------------------------------------------
// cwk_blend
// Blend rotated chroma with the original by alpha/255, clamp and recenter.
// Two register stages, the second is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwk_blend (
  input  logic                             clk_i,
  input  logic [cwk_pkg::BlendStages-1:0]  load_i,
  input  cwk_pkg::cwk_alpha_t              alpha_i,
  output cwk_pkg::cwk_out_t                pix_o
);
  import cwk_pkg::*;

  // Clamp a signed quotient, given as sign and magnitude, to -128..127
  // and add 128
  function automatic logic [7:0] clamp_out(input logic neg, input logic [12:0] q);
    logic [7:0] r;
    if (!neg) begin
      r = (q > 13'd127) ? 8'd255 : {1'b1, q[6:0]};
    end else begin
      r = (q > 13'd128) ? 8'd0 : (8'd128 - q[7:0]);
    end
    return r;
  endfunction

  // ---------------- stage 4: weighted sum, sign and magnitude ----------------
  // With alpha zero the sum is the original times 255, so the pair passes
  // through unchanged without a separate bypass.
  logic signed [8:0]  a_s_c, ac_s_c;
  logic signed [20:0] nua_c, nva_c;
  logic signed [16:0] uac_c, vac_c;
  logic signed [20:0] su_c, sv_c;
  logic        [19:0] magu_d, magv_d;

  logic [19:0] magu_q, magv_q;
  logic        negu_q, negv_q;

  assign a_s_c  = signed'({1'b0, alpha_i.alpha});
  assign ac_s_c = signed'({1'b0, ~alpha_i.alpha});

  assign nua_c = 21'($signed(alpha_i.nu)) * 21'(a_s_c);
  assign nva_c = 21'($signed(alpha_i.nv)) * 21'(a_s_c);
  assign uac_c = 17'($signed(alpha_i.u)) * 17'(ac_s_c);
  assign vac_c = 17'($signed(alpha_i.v)) * 17'(ac_s_c);

  assign su_c = nua_c + 21'(uac_c);
  assign sv_c = nva_c + 21'(vac_c);

  assign magu_d = su_c[20] ? 20'(-su_c) : su_c[19:0];
  assign magv_d = sv_c[20] ? 20'(-sv_c) : sv_c[19:0];

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      magu_q <= magu_d;
      magv_q <= magv_d;
      negu_q <= su_c[20];
      negv_q <= sv_c[20];
    end
  end

  // ---------------- stage 5: divide by 255, clamp, output register ----------------
  logic [41:0] qu_prod_c, qv_prod_c;
  logic [12:0] qu_c, qv_c;

  cwk_out_t out_q;

  assign qu_prod_c = 42'(magu_q) * 42'(Recip255);
  assign qv_prod_c = 42'(magv_q) * 42'(Recip255);
  assign qu_c      = qu_prod_c[RecipShift+12:RecipShift];
  assign qv_c      = qv_prod_c[RecipShift+12:RecipShift];

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      out_q.cb_out <= clamp_out(negu_q, qu_c);
      out_q.cr_out <= clamp_out(negv_q, qv_c);
    end
  end

  assign pix_o = out_q;

endmodule

`default_nettype wire

[rtl/chroma_wedge_key_hue_rotate.sv]
// ----------------------------------------------------------------------------
// chroma_wedge_key_hue_rotate
// Per-pixel chroma keyer and hue rotator on a five stage pipeline.
//
//   channel   direction  transfer                   payload
//   pix_i     in         pix_i.valid & pix_i.ready  cb_in, cr_in
//   pix_o     out        pix_o.valid & pix_o.ready  cb_out, cr_out
//   cfg       in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle while pix_o.ready stays high; each result passes through
// the five register stages: key frame multiply, wedge distance and rotation
// multiply, gain multiply, blend multiply, and the divide-by-255 reciprocal
// multiply that feeds the output register.
// Reset clears the valid bits and loads the register defaults.
// On an output stall the empty stages keep filling; ready drops once all
// five stages hold an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chroma_wedge_key_hue_rotate (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cwk_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cwk_pkg::CfgDataW-1:0]   cfg_wdata_i,
  cwk_stream_if.sink                     pix_i,
  cwk_stream_if.source                   pix_o
);
  import cwk_pkg::*;

  cwk_cfg_t             cfg_q, cfg_d;
  logic [NumStages-1:0] load_c;
  logic                 in_ready_c;
  logic                 out_valid_c;
  cwk_in_t              pix_in_c;
  cwk_alpha_t           alpha_c;
  cwk_out_t             pix_out_c;

  // Decode register writes; only the register's low bits are kept
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cwk_reg_e'(cfg_idx_i))
        RegKeyCos:        cfg_d.key_cos             = cfg_wdata_i[13:0];
        RegKeySin:        cfg_d.key_sin             = cfg_wdata_i[13:0];
        RegKeyOffset:     cfg_d.key_offset          = cfg_wdata_i[21:0];
        RegWedgeInvSlope: cfg_d.wedge_inverse_slope = cfg_wdata_i[26:0];
        RegRangeGain:     cfg_d.range_gain          = cfg_wdata_i[15:0];
        RegRotateCos:     cfg_d.rotate_cos          = cfg_wdata_i[18:0];
        RegRotateSin:     cfg_d.rotate_sin          = cfg_wdata_i[18:0];
        RegInvertKey:     cfg_d.invert_key          = cfg_wdata_i[0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline control
  cwk_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (in_ready_c),
    .out_valid_o (out_valid_c),
    .out_ready_i (pix_o.ready),
    .load_o      (load_c)
  );

  assign pix_in_c = pix_i.payload;

  // Key alpha stages
  cwk_alpha u_alpha (
    .clk_i   (clk_i),
    .load_i  (load_c[AlphaStages-1:0]),
    .pix_i   (pix_in_c),
    .cfg_i   (cfg_q),
    .alpha_o (alpha_c)
  );

  // Blend stages
  cwk_blend u_blend (
    .clk_i   (clk_i),
    .load_i  (load_c[NumStages-1:AlphaStages]),
    .alpha_i (alpha_c),
    .pix_o   (pix_out_c)
  );

  assign pix_i.ready   = in_ready_c;
  assign pix_o.valid   = out_valid_c;
  assign pix_o.payload = pix_out_c;

endmodule

`default_nettype wire

[rtl/cwk_checker.sv]
// ----------------------------------------------------------------------------
// cwk_checker
// Port-level checks of the keyer: output hold, reset, and pipeline occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cwk_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  cwk_pkg::cwk_out_t  out_data_i
);
  import cwk_pkg::*;

  localparam int OccW = $clog2(NumStages + 1);

  logic [OccW-1:0] occ_q, occ_d;
  logic            in_xfer_c, out_xfer_c;

  assign in_xfer_c  = in_valid_i && in_ready_i;
  assign out_xfer_c = out_valid_i && out_ready_i;

  // Track items in flight from the port transfers
  assign occ_d = occ_q + OccW'(in_xfer_c) - OccW'(out_xfer_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `CWK_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
  `CWK_ASSERT_RESET(a_reset_idle, !rst_ni |-> !out_valid_i)
  `CWK_ASSERT(a_out_has_item, out_valid_i |-> occ_q != '0)
  `CWK_ASSERT(a_full_on_backpressure, !in_ready_i |-> occ_q == OccW'(NumStages))

endmodule

bind chroma_wedge_key_hue_rotate cwk_checker u_cwk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_data_i  (pix_o.payload)
);

`default_nettype wire

[tb/sv/chroma_wedge_key_hue_rotate_test.sv]
// ----------------------------------------------------------------------------
// chroma_wedge_key_hue_rotate_test
// Self-checking bench for the chroma wedge keyer and hue rotator. A directed
// table of pixels runs first, under the reset defaults and a few hand-picked
// register sets. Extreme, then random register sets with random pixels follow.
// Each pixel in gets a hand-written expected result or one from a local model
// of the key and blend arithmetic, and each output transfer is checked against
// the oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chroma_wedge_key_hue_rotate_test;

  import cwk_pkg::*;

  // Directed register sets
  localparam int SetReset       = 0;
  localparam int SetNegate      = 1;
  localparam int SetQuarterTurn = 2;
  localparam int SetSaturate    = 3;

  localparam int RandomPixels = 400;

  typedef struct {
    int       setting;
    cwk_in_t  px;
    bit       typed;
    cwk_out_t want;
  } probe_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  cwk_stream_if #(.payload_t(cwk_in_t))  pix_in ();
  cwk_stream_if #(.payload_t(cwk_out_t)) pix_out ();

  chroma_wedge_key_hue_rotate uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  cwk_cfg_t key_regs;
  cwk_out_t expected_chroma [$];
  probe_t   probes [$];
  bit       calm;
  int       pixels_sent;
  int       results_checked;
  int       chroma_errors;
  int       settings_loaded;

  // Free-running clock, 4 ns period
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Key alpha, rotation and blend of one pixel under the given registers
  function automatic cwk_out_t predict_chroma(input cwk_cfg_t c, input cwk_in_t px);
    longint u, v, x, y, ay, wdist, alpha, nu, nv, bu, bv;
    cwk_out_t res;
    u  = longint'(px.cb_in) - 128;
    v  = longint'(px.cr_in) - 128;
    x  = (u * longint'($signed(c.key_cos)) + v * longint'($signed(c.key_sin))) >>> 12;
    y  = (v * longint'($signed(c.key_cos)) - u * longint'($signed(c.key_sin))) >>> 12;
    ay = (y < 0) ? -y : y;
    wdist = longint'($signed(c.key_offset)) - x * 4096
          + ay * longint'($signed(c.wedge_inverse_slope));
    // Clamp the full-width product, no wrap in between
    alpha = (wdist * longint'(c.range_gain)) >>> 20;
    if (alpha < 0) alpha = 0;
    if (alpha > 255) alpha = 255;
    if (c.invert_key) alpha = 255 - alpha;
    res.cb_out = px.cb_in;
    res.cr_out = px.cr_in;
    if (alpha > 0) begin
      nu = (longint'($signed(c.rotate_cos)) * u - longint'($signed(c.rotate_sin)) * v
            + RotRound) >>> 16;
      nv = (longint'($signed(c.rotate_sin)) * u + longint'($signed(c.rotate_cos)) * v
            + RotRound) >>> 16;
      // Signed divide truncates toward zero
      bu = (nu * alpha + u * (255 - alpha)) / 255;
      bv = (nv * alpha + v * (255 - alpha)) / 255;
      if (bu < -128) bu = -128;
      if (bu > 127)  bu = 127;
      if (bv < -128) bv = -128;
      if (bv > 127)  bv = 127;
      res.cb_out = 8'(bu + 128);
      res.cr_out = 8'(bv + 128);
    end
    return res;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pick an edge of the legal range, raw bits, the full range or a usable band
  function automatic longint pick_value(input longint lo, input longint hi,
                                        input longint tlo, input longint thi);
    case ($urandom_range(0, 9))
      0:       return lo;
      1:       return hi;
      2:       return longint'($urandom);
      3, 4, 5: return lo + longint'($urandom_range(0, int'(hi - lo)));
      default: return tlo + longint'($urandom_range(0, int'(thi - tlo)));
    endcase
  endfunction

  function automatic cwk_cfg_t random_config();
    cwk_cfg_t c;
    c.key_cos             = 14'(pick_value(-4096, 4096, -4096, 4096));
    c.key_sin             = 14'(pick_value(-4096, 4096, -4096, 4096));
    c.key_offset          = 22'(pick_value(-1048576, 1048576, -262144, 262144));
    c.wedge_inverse_slope = 27'(pick_value(-40960000, 40960000, 0, 16384));
    c.range_gain          = 16'(pick_value(0, 65280, 0, 1024));
    c.rotate_cos          = 19'(pick_value(-167773, 167773, -98304, 98304));
    c.rotate_sin          = 19'(pick_value(-167773, 167773, -98304, 98304));
    c.invert_key          = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Every register at the top or the bottom of its range
  function automatic cwk_cfg_t extreme_config(input bit hi);
    cwk_cfg_t c;
    c.key_cos             = hi ? 14'sd4096 : -14'sd4096;
    c.key_sin             = hi ? 14'sd4096 : -14'sd4096;
    c.key_offset          = hi ? 22'sd1048576 : -22'sd1048576;
    c.wedge_inverse_slope = hi ? 27'sd40960000 : -27'sd40960000;
    c.range_gain          = hi ? 16'd65280 : 16'd0;
    c.rotate_cos          = hi ? 19'sd167773 : -19'sd167773;
    c.rotate_sin          = hi ? 19'sd167773 : -19'sd167773;
    c.invert_key          = hi;
    return c;
  endfunction

  function automatic cwk_cfg_t directed_config(input int setting);
    cwk_cfg_t c;
    c = CfgRst;
    case (setting)
      SetNegate: begin
        // Full key, chroma negated
        c.key_offset = 22'sd1048576;
        c.range_gain = 16'd65280;
        c.rotate_cos = -19'sd65536;
      end
      SetQuarterTurn: begin
        // Zero gain inverted to full alpha, quarter turn of hue
        c.range_gain = 16'd0;
        c.invert_key = 1'b1;
        c.rotate_cos = 19'sd0;
        c.rotate_sin = 19'sd65536;
      end
      SetSaturate: begin
        // Products far past 32 bits, saturated rotation
        c.key_cos             = -14'sd4096;
        c.key_sin             = 14'sd4096;
        c.key_offset          = -22'sd1048576;
        c.wedge_inverse_slope = 27'sd40960000;
        c.range_gain          = 16'd65280;
        c.rotate_cos          = 19'sd167773;
        c.rotate_sin          = -19'sd167773;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic cwk_in_t random_pixel();
    cwk_in_t px;
    px.cb_in = 8'($urandom_range(0, 255));
    px.cr_in = 8'($urandom_range(0, 255));
    // Pull one component to an extreme or to the center now and then
    case ($urandom_range(0, 15))
      0:       px.cb_in = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      1:       px.cr_in = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      2:       px.cb_in = 8'd128;
      default: ;
    endcase
    return px;
  endfunction

  function automatic void add_probe(input int setting, input int cb, input int cr,
                                    input bit typed = 1'b0,
                                    input int wcb = 0, input int wcr = 0);
    probe_t p;
    p.setting     = setting;
    p.px.cb_in    = 8'(cb);
    p.px.cr_in    = 8'(cr);
    p.typed       = typed;
    p.want.cb_out = 8'(wcb);
    p.want.cr_out = 8'(wcr);
    probes.push_back(p);
  endfunction

  // Offer one pixel after a random gap and hold it until it transfers
  task automatic send_pixel(input cwk_in_t px, input bit typed, input cwk_out_t want);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid   <= 1'b1;
    pix_in.payload <= px;
    do @(posedge clk_i); while (!(pix_in.valid && pix_in.ready));
    expected_chroma.push_back(typed ? want : predict_chroma(key_regs, px));
    pixels_sent++;
  endtask

  // Drop valid, wait for every result, then let the pipeline run dry
  task automatic settle();
    pix_in.valid <= 1'b0;
    while (expected_chroma.size() != 0) @(posedge clk_i);
    repeat (NumStages + 2) @(posedge clk_i);
  endtask

  // Write one register; bits above its width carry noise
  task automatic write_reg(input cwk_reg_e idx, input logic [CfgDataW-1:0] field,
                           input int width);
    logic [CfgDataW-1:0] noise, mask;
    noise = CfgDataW'($urandom);
    mask  = (CfgDataW'(1) << width) - CfgDataW'(1);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= (field & mask) | (noise & ~mask);
    @(posedge clk_i);
  endtask

  task automatic load_config(input cwk_cfg_t c);
    write_reg(RegKeyCos,        CfgDataW'(c.key_cos), 14);
    write_reg(RegKeySin,        CfgDataW'(c.key_sin), 14);
    write_reg(RegKeyOffset,     CfgDataW'(c.key_offset), 22);
    write_reg(RegWedgeInvSlope, CfgDataW'(c.wedge_inverse_slope), 27);
    write_reg(RegRangeGain,     CfgDataW'(c.range_gain), 16);
    write_reg(RegRotateCos,     CfgDataW'(c.rotate_cos), 19);
    write_reg(RegRotateSin,     CfgDataW'(c.rotate_sin), 19);
    write_reg(RegInvertKey,     CfgDataW'(c.invert_key), 1);
    cfg_we   <= 1'b0;
    key_regs = c;
    settings_loaded++;
  endtask

  // Output side: random stalls, quiet while calm
  initial begin : output_stall
    int hold;
    pix_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = calm ? 0 : pick_gap();
      if (hold > 0) begin
        pix_out.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      pix_out.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Check each output transfer against the oldest prediction
  always @(posedge clk_i) begin : check_chroma
    cwk_out_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      results_checked++;
      if (expected_chroma.size() == 0) begin
        chroma_errors++;
        if (chroma_errors <= 10)
          $display("%0t: result with nothing expected: cb %0d cr %0d", $realtime,
                   pix_out.payload.cb_out, pix_out.payload.cr_out);
      end else begin
        want = expected_chroma.pop_front();
        if (pix_out.payload.cb_out !== want.cb_out ||
            pix_out.payload.cr_out !== want.cr_out) begin
          chroma_errors++;
          if (chroma_errors <= 10)
            $display("%0t: mismatch: expected cb %0d cr %0d, got cb %0d cr %0d",
                     $realtime, want.cb_out, want.cr_out,
                     pix_out.payload.cb_out, pix_out.payload.cr_out);
        end
      end
    end
  end

  initial begin : stimulus
    int       cur_setting;
    int       phase;
    int       directed;
    cwk_cfg_t cfg;
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= RegKeyCos;
    cfg_wdata      <= '0;
    pix_in.valid   <= 1'b0;
    pix_in.payload <= '0;
    key_regs        = CfgRst;
    calm            = 1'b0;
    pixels_sent     = 0;
    results_checked = 0;
    chroma_errors   = 0;
    settings_loaded = 0;

    // Reset defaults pass every pixel through unchanged
    add_probe(SetReset, 0, 0, 1, 0, 0);
    add_probe(SetReset, 255, 255, 1, 255, 255);
    add_probe(SetReset, 0, 255, 1, 0, 255);
    add_probe(SetReset, 255, 0, 1, 255, 0);
    add_probe(SetReset, 128, 128, 1, 128, 128);
    add_probe(SetReset, 127, 129, 1, 127, 129);
    add_probe(SetReset, 1, 254, 1, 1, 254);
    add_probe(SetReset, 8'hAA, 8'h55, 1, 8'hAA, 8'h55);
    add_probe(SetReset, 8'h55, 8'hAA, 1, 8'h55, 8'hAA);
    // Full alpha with negated chroma; -(-128) clamps to 127
    add_probe(SetNegate, 0, 0, 1, 255, 255);
    add_probe(SetNegate, 255, 255, 1, 1, 1);
    add_probe(SetNegate, 128, 0, 1, 128, 255);
    add_probe(SetNegate, 1, 200, 1, 255, 56);
    add_probe(SetNegate, 64, 255, 1, 192, 1);
    // Inverted zero gain and a quarter turn
    add_probe(SetQuarterTurn, 0, 0);
    add_probe(SetQuarterTurn, 255, 128);
    add_probe(SetQuarterTurn, 128, 255);
    add_probe(SetQuarterTurn, 37, 211);
    // Alpha saturation on wide products
    add_probe(SetSaturate, 0, 255);
    add_probe(SetSaturate, 255, 0);
    add_probe(SetSaturate, 128, 128);
    add_probe(SetSaturate, 200, 60);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table, reloading registers where the set changes
    cur_setting = SetReset;
    foreach (probes[i]) begin
      if (probes[i].setting != cur_setting) begin
        settle();
        load_config(directed_config(probes[i].setting));
        cur_setting = probes[i].setting;
      end
      send_pixel(probes[i].px, probes[i].typed, probes[i].want);
    end
    directed = pixels_sent;

    // Random bursts, each under a fresh register set
    phase = 0;
    while (pixels_sent - directed < RandomPixels) begin
      settle();
      if (phase < 2) cfg = extreme_config(phase[0]);
      else cfg = random_config();
      load_config(cfg);
      calm = (phase % 4 == 3);
      repeat ($urandom_range(30, 70)) send_pixel(random_pixel(), 1'b0, '0);
      phase++;
    end
    calm = 1'b0;
    settle();

    $display("Run covered %0d pixels (%0d directed) over %0d register sets, %0d results checked",
             pixels_sent, directed, settings_loaded, results_checked);
    $display("Mismatches: %0d", chroma_errors);
    if (chroma_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
